// ----- rtl/core/hfr_pkg.sv -----
`default_nettype none
package hfr_pkg;
  localparam int unsigned SECTIONS_DEF   = 4;
  localparam int unsigned MAX_VALUES_DEF = 64;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned MAX_RESULTS    = 64;

  localparam logic [2:0] ST_RECORDED = 3'd0;
  localparam logic [2:0] ST_OUTSIDE  = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_RANKED   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic [2:0] REG_MIN_LINE   = 3'd0;
  localparam logic [2:0] REG_MAX_LINE   = 3'd1;
  localparam logic [2:0] REG_UPPER_ON   = 3'd2;
  localparam logic [2:0] REG_DESCENDING = 3'd3;
  localparam logic [2:0] REG_VALUE_CNT  = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REC_RD,
    S_REC_WR,
    S_SCAN_ISSUE,
    S_SCAN,
    S_SCAN_LAST,
    S_EMIT,
    S_DONE
  } hfr_state_t;

  // Outputs of the control sequencer.
  typedef struct packed {
    logic       out_valid;
    logic [2:0] status;
    logic       last;
  } hfr_out_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/core/histogram_frequency_ranker_core.sv -----
`default_nettype none
// Per-section histogram with a ranked readout. The counters live in one
// SECTIONS*MAX_VALUES-entry RAM, which is swept clear after reset before
// start is honored. A counted record passes through the read, modify and
// write, and result states and gives one result; a record outside the window
// or out of range, and an empty query, go straight to the result state.
// A query selects one rank per full walk of the section through the RAM read
// port; the walk runs start+n times, where start = block_index*block_size and
// n the entries emitted, and only the last n walks give a result. The
// receiver cannot stall: each result sits on the out_ ports for one cycle
// with out_valid high, and busy stays high until the last one has gone out.
module histogram_frequency_ranker_core
  import hfr_pkg::*;
#(
  parameter int unsigned SECTIONS   = SECTIONS_DEF,
  parameter int unsigned MAX_VALUES = MAX_VALUES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [1:0]  in_section,
  input  wire logic [15:0] in_line,
  input  wire logic [6:0]  in_number,
  input  wire logic [6:0]  in_count,
  input  wire logic [6:0]  in_block_index,
  input  wire logic [6:0]  in_block_size,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [6:0]       out_ranked_number,
  output logic [15:0]      out_hits,
  output logic             out_last
);
  localparam int unsigned SB  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int unsigned VB  = $clog2(MAX_VALUES);
  localparam int unsigned VCB = $clog2(MAX_VALUES + 1);
  localparam int unsigned AB  = $clog2(SECTIONS * MAX_VALUES);
  localparam int unsigned DEPTH = SECTIONS * MAX_VALUES;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  hfr_state_t state_r, state_nxt;
  hfr_out_ctl_t octl;

  logic [15:0] min_line_r, max_line_r;
  logic        upper_on_r, desc_r;
  logic [6:0]  value_count_r;

  logic [AB-1:0]   clr_addr_r;
  logic [SB-1:0]   sec_r;
  logic [VB-1:0]   idx_r;       // number index of the word in flight
  logic [VB-1:0]   scan_r;      // read pointer of the walk
  logic [VCB-1:0]  vc_r;
  logic [7:0]      rank_r, start_r, end_r;
  logic [MAX_VALUES-1:0] emitted_r;
  logic            best_ok_r;
  logic [VB-1:0]   best_idx_r;
  logic [COUNT_BITS-1:0] best_cnt_r;
  logic [2:0]      res_status_r;
  logic [COUNT_BITS-1:0] res_hits_r;

  logic                  we;
  logic [AB-1:0]         waddr, raddr;
  logic [COUNT_BITS-1:0] wdata, rdata;

  hfr_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_cnt (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Input decode.
  logic [31:0]    sec_mod;
  logic [SB-1:0]  in_sec;
  logic [VCB-1:0] vc_live;
  logic [6:0]     num1;
  logic [13:0]    start_full;
  logic [7:0]     n_raw, n_sel;
  logic           in_window, q_empty;
  always_comb begin
    // The section field is two bits wide, so three compare-and-subtract
    // steps are enough to reduce it modulo SECTIONS.
    sec_mod = 32'(in_section);
    for (int i = 0; i < 3; i++) begin
      if (sec_mod >= SECTIONS) sec_mod = sec_mod - SECTIONS;
    end
    in_sec = SB'(sec_mod);
    if (value_count_r == 7'd0) vc_live = VCB'(1);
    else if (32'(value_count_r) > MAX_VALUES) vc_live = VCB'(MAX_VALUES);
    else vc_live = VCB'(value_count_r);
    num1 = (in_number == 7'd0) ? 7'd1 : in_number;
    in_window = !(in_line < min_line_r || (upper_on_r && in_line > max_line_r));
    start_full = 14'(in_block_index * in_block_size);
    q_empty = (32'(start_full) >= 32'(vc_live)) || (in_count == 7'd0);
    n_raw = 8'(32'(vc_live) - 32'(start_full));
    n_sel = (8'(in_count) < n_raw) ? 8'(in_count) : n_raw;
    if (32'(n_sel) > MAX_RESULTS) n_sel = 8'(MAX_RESULTS);
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Candidate comparison for the walk.
  logic [VB-1:0] cand_idx;
  logic cand_better;
  always_comb begin
    cand_idx = idx_r;
    if (emitted_r[cand_idx]) cand_better = 1'b0;
    else if (!best_ok_r) cand_better = 1'b1;
    else if (rdata != best_cnt_r)
      cand_better = desc_r ? (rdata > best_cnt_r) : (rdata < best_cnt_r);
    else cand_better = 1'b0;  // later index never wins a tie
  end

  logic scan_end;
  assign scan_end = (32'(scan_r) + 1 >= 32'(vc_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:      if (32'(clr_addr_r) == DEPTH - 1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (!in_op) begin
            state_nxt = (in_window && 32'(num1) <= 32'(vc_live)) ? S_REC_RD : S_DONE;
          end else begin
            state_nxt = q_empty ? S_DONE : S_SCAN_ISSUE;
          end
        end
      end
      S_REC_RD:     state_nxt = S_REC_WR;
      S_REC_WR:     state_nxt = S_DONE;
      S_SCAN_ISSUE: state_nxt = scan_end ? S_SCAN_LAST : S_SCAN;
      S_SCAN:       state_nxt = scan_end ? S_SCAN_LAST : S_SCAN;
      S_SCAN_LAST:  state_nxt = S_EMIT;
      S_EMIT:       state_nxt = (rank_r + 8'd1 == end_r) ? S_IDLE : S_SCAN_ISSUE;
      S_DONE:       state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    octl = '0;
    case (state_r)
      S_DONE: begin
        octl.out_valid = 1'b1;
        octl.status = res_status_r;
        octl.last = 1'b1;
      end
      S_EMIT: begin
        octl.out_valid = (rank_r >= start_r);
        octl.status = ST_RANKED;
        octl.last = (rank_r + 8'd1 == end_r);
      end
      default: octl = '0;
    endcase
  end

  // RAM ports.
  always_comb begin
    we = 1'b0;
    waddr = clr_addr_r;
    wdata = '0;
    raddr = AB'({32'(sec_r) * MAX_VALUES + 32'(scan_r)});
    if (state_r == S_CLEAR) begin
      we = 1'b1;
    end else if (state_r == S_REC_WR) begin
      we = 1'b1;
      waddr = AB'(32'(sec_r) * MAX_VALUES + 32'(idx_r));
      wdata = (rdata == CMAX) ? rdata : rdata + COUNT_BITS'(1);
    end
    if (state_r == S_IDLE) begin
      raddr = AB'(32'(in_sec) * MAX_VALUES + 32'(num1) - 1);
    end else if (state_r == S_REC_RD) begin
      // Keep the counter word on the read port for the write-back cycle.
      raddr = AB'(32'(sec_r) * MAX_VALUES + 32'(idx_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_addr_r <= '0;
      min_line_r <= 16'd0;
      max_line_r <= 16'hFFFF;
      upper_on_r <= 1'b0;
      desc_r <= 1'b0;
      value_count_r <= 7'd64;
      emitted_r <= '0;
      best_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + AB'(1);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_LINE:   min_line_r <= cfg_data;
          REG_MAX_LINE:   max_line_r <= cfg_data;
          REG_UPPER_ON:   upper_on_r <= cfg_data[0];
          REG_DESCENDING: desc_r <= cfg_data[0];
          REG_VALUE_CNT:  value_count_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (accept) emitted_r <= '0;
      case (state_r)
        S_SCAN_ISSUE: best_ok_r <= 1'b0;
        S_SCAN, S_SCAN_LAST: if (cand_better) best_ok_r <= 1'b1;
        S_EMIT: emitted_r[best_idx_r] <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      sec_r <= in_sec;
      idx_r <= VB'(num1 - 7'd1);
      vc_r <= vc_live;
      rank_r <= 8'd0;
      start_r <= 8'(start_full);
      end_r <= 8'(start_full) + n_sel;
      if (!in_op) res_status_r <= !in_window ? ST_OUTSIDE :
                                  (32'(num1) > 32'(vc_live)) ? ST_RANGE : ST_RECORDED;
      else res_status_r <= ST_EMPTY;
      res_hits_r <= '0;
    end
    case (state_r)
      S_REC_WR: res_hits_r <= (rdata == CMAX) ? rdata : rdata + COUNT_BITS'(1);
      S_SCAN_ISSUE: begin
        idx_r <= '0;
        scan_r <= scan_end ? scan_r : scan_r + VB'(1);
      end
      S_SCAN, S_SCAN_LAST: begin
        if (cand_better) begin
          best_idx_r <= cand_idx;
          best_cnt_r <= rdata;
        end
        idx_r <= idx_r + VB'(1);
        if (!scan_end) scan_r <= scan_r + VB'(1);
      end
      S_EMIT: begin
        rank_r <= rank_r + 8'd1;
        scan_r <= '0;
      end
      default: ;
    endcase
    if (state_r == S_IDLE) scan_r <= '0;
  end

  always_comb begin
    out_valid = octl.out_valid;
    out_status = octl.status;
    out_last = octl.last;
    out_ranked_number = (state_r == S_EMIT) ? 7'(32'(best_idx_r) + 1) : 7'd0;
    out_hits = (state_r == S_EMIT) ? 16'(best_cnt_r) : 16'(res_hits_r);
  end

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !busy)
    else $error("busy after last result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start) && $past(busy) && busy |-> !out_valid || busy)
    else $error("state error");
  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> best_ok_r)
    else $error("walk found no candidate");
endmodule
`default_nettype wire

// ----- rtl/core/hfr_ram.sv -----
`default_nettype none
module hfr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import hfr_pkg::*;

  localparam int unsigned NUM_SECTIONS = 4;
  localparam int unsigned NUM_VALUES   = 64;
  localparam int unsigned MAX_SLICE    = 64;

  typedef struct {
    logic        op;
    logic [1:0]  section;
    logic [15:0] line;
    logic [6:0]  number;
    logic [6:0]  count;
    logic [6:0]  block_index;
    logic [6:0]  block_size;
  } hist_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [6:0]  ranked_number;
    logic [15:0] hits;
    logic        last;
  } hist_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = 1'b0;
  logic [1:0]  in_section = '0;
  logic [15:0] in_line = '0;
  logic [6:0]  in_number = '0;
  logic [6:0]  in_count = '0;
  logic [6:0]  in_block_index = '0;
  logic [6:0]  in_block_size = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [6:0]  out_ranked_number;
  logic [15:0] out_hits;
  logic        out_last;

  // Shadow copy of the histogram and of the window settings.
  logic [15:0] hist_counts [NUM_SECTIONS][NUM_VALUES];
  logic [15:0] win_min_line;
  logic [15:0] win_max_line;
  logic        win_upper_on;
  logic        rank_descending;
  logic [6:0]  tracked_values;

  hist_result_t pending_results [$];
  int          mismatch_count = 0;
  bit          no_gaps = 1'b0;

  always #4 clk = ~clk;

  histogram_frequency_ranker_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_section(in_section), .in_line(in_line), .in_number(in_number),
    .in_count(in_count), .in_block_index(in_block_index), .in_block_size(in_block_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_status(out_status),
    .out_ranked_number(out_ranked_number), .out_hits(out_hits), .out_last(out_last)
  );

  function automatic bit ranks_ahead(logic [15:0] ca, logic [15:0] cb, int a, int b);
    if (ca != cb) return rank_descending ? (ca > cb) : (ca < cb);
    return a < b;
  endfunction

  function automatic void add_expected(hist_result_t r);
    pending_results = {pending_results, r};
  endfunction

  task automatic predict_histogram(hist_item_t it);
    hist_result_t r;
    int vc;
    int sec;
    int num;
    int first_rank;
    int n;
    int stop_rank;
    int best;
    bit taken [NUM_VALUES];
    vc = (tracked_values == 0) ? 1 : (tracked_values > NUM_VALUES) ? NUM_VALUES
         : tracked_values;
    sec = it.section % NUM_SECTIONS;
    r.ranked_number = '0;
    r.hits = '0;
    r.last = 1'b1;
    if (it.op == 1'b0) begin
      num = (it.number == 0) ? 1 : it.number;
      if (it.line < win_min_line || (win_upper_on && it.line > win_max_line)) begin
        r.status = ST_OUTSIDE;
      end else if (num > vc) begin
        r.status = ST_RANGE;
      end else begin
        if (hist_counts[sec][num-1] != 16'hFFFF) hist_counts[sec][num-1]++;
        r.status = ST_RECORDED;
        r.hits = hist_counts[sec][num-1];
      end
      add_expected(r);
      return;
    end
    first_rank = it.block_index * it.block_size;
    if (first_rank >= vc || it.count == 0) begin
      r.status = ST_EMPTY;
      add_expected(r);
      return;
    end
    n = vc - first_rank;
    if (it.count < n) n = it.count;
    if (n > MAX_SLICE) n = MAX_SLICE;
    stop_rank = first_rank + n;
    foreach (taken[j]) taken[j] = 1'b0;
    // Selection walk: pick the best remaining number once per rank.
    for (int rank = 0; rank < stop_rank; rank++) begin
      best = -1;
      for (int j = 0; j < vc; j++) begin
        if (!taken[j] && (best < 0 ||
            ranks_ahead(hist_counts[sec][j], hist_counts[sec][best], j, best)))
          best = j;
      end
      taken[best] = 1'b1;
      if (rank >= first_rank) begin
        r.status = ST_RANKED;
        r.ranked_number = 7'(best + 1);
        r.hits = hist_counts[sec][best];
        r.last = (rank + 1 == stop_rank);
        add_expected(r);
      end
    end
  endtask

  always @(posedge clk) begin
    hist_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d number %0d hits %0d last %0d",
                   out_status, out_ranked_number, out_hits, out_last);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status || out_ranked_number !== e.ranked_number ||
            out_hits !== e.hits || out_last !== e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     e.status, e.ranked_number, e.hits, e.last,
                     out_status, out_ranked_number, out_hits, out_last);
        end
      end
    end
  end

  // Start stays high between back-to-back items; gaps lower it.
  task automatic send_item(hist_item_t it);
    if (!no_gaps && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= it.op;
    in_section <= it.section;
    in_line <= it.line;
    in_number <= it.number;
    in_count <= it.count;
    in_block_index <= it.block_index;
    in_block_size <= it.block_size;
    do @(posedge clk); while (busy);
    predict_histogram(it);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_LINE:   win_min_line = val;
      REG_MAX_LINE:   win_max_line = val;
      REG_UPPER_ON:   win_upper_on = val[0];
      REG_DESCENDING: rank_descending = val[0];
      REG_VALUE_CNT:  tracked_values = val[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] lo, logic [15:0] hi, logic up, logic desc,
                           logic [6:0] vc);
    drain_results();
    write_reg(REG_MIN_LINE, lo);
    write_reg(REG_MAX_LINE, hi);
    write_reg(REG_UPPER_ON, 16'(up));
    write_reg(REG_DESCENDING, 16'(desc));
    write_reg(REG_VALUE_CNT, 16'(vc));
    cfg_valid <= 1'b0;
  endtask

  function automatic hist_item_t make_record(int sec, int ln, int num);
    hist_item_t it;
    it.op = 1'b0;
    it.section = 2'(sec);
    it.line = 16'(ln);
    it.number = 7'(num);
    it.count = 7'($urandom_range(127));
    it.block_index = 7'($urandom_range(127));
    it.block_size = 7'($urandom_range(127));
    return it;
  endfunction

  function automatic hist_item_t make_query(int sec, int cnt, int bi, int bs);
    hist_item_t it;
    it.op = 1'b1;
    it.section = 2'(sec);
    it.line = 16'($urandom_range(65535));
    it.number = 7'($urandom_range(127));
    it.count = 7'(cnt);
    it.block_index = 7'(bi);
    it.block_size = 7'(bs);
    return it;
  endfunction

  function automatic hist_item_t random_item();
    hist_item_t it;
    if ($urandom_range(99) < 75) begin
      // Small numbers repeat often so the counts differ and ties break.
      it = make_record($urandom_range(3), $urandom_range(65535),
                       ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(8));
    end else if ($urandom_range(9) == 0) begin
      it = make_query($urandom_range(3), $urandom_range(64), $urandom_range(64),
                      $urandom_range(64));
    end else begin
      it = make_query($urandom_range(3), $urandom_range(12), $urandom_range(3),
                      $urandom_range(6));
    end
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_query(0, 64, 0, 0));
    send_item(make_record(0, 0, 0));
    send_item(make_record(0, 65535, 1));
    send_item(make_record(1, 1234, 64));
    send_item(make_record(2, 7, 63));
    send_item(make_record(3, 9, 127));
    send_item(make_record(3, 9, 65));
    send_item(make_query(0, 0, 0, 0));
    send_item(make_query(0, 3, 64, 1));
    send_item(make_query(1, 5, 1, 63));
    send_item(make_query(3, 127, 0, 0));
    send_item(make_query(2, 64, 127, 127));
  endtask

  task automatic test_window();
    configure(16'd100, 16'd200, 1'b1, 1'b1, 7'd8);
    send_item(make_record(0, 99, 2));
    send_item(make_record(0, 100, 2));
    send_item(make_record(0, 200, 3));
    send_item(make_record(0, 201, 3));
    send_item(make_record(0, 50, 9));
    send_item(make_record(0, 150, 9));
    send_item(make_record(0, 150, 0));
    send_item(make_query(0, 8, 0, 4));
    configure(16'd65535, 16'd0, 1'b0, 1'b0, 7'd1);
    send_item(make_record(1, 65535, 0));
    send_item(make_record(1, 65534, 1));
    send_item(make_record(1, 65535, 2));
    send_item(make_query(1, 1, 0, 0));
    send_item(make_query(1, 1, 1, 1));
  endtask

  task automatic test_random();
    configure(16'd0, 16'd65535, 1'b0, 1'b0, 7'd8);
    repeat (70) send_item(random_item());
    configure(16'd0, 16'd40000, 1'b1, 1'b1, 7'd64);
    no_gaps = 1'b1;
    repeat (60) send_item(random_item());
    no_gaps = 1'b0;
    drain_results();
    repeat (30) send_item(random_item());
    configure(16'($urandom_range(20000)), 16'd65535, 1'b1, 1'b1, 7'd5);
    repeat (70) send_item(random_item());
    configure(16'd0, 16'hFFFF, 1'b0, 1'b0, 7'd0);
    repeat (25) send_item(random_item());
    configure(16'd10, 16'd60000, 1'b1, 1'b0, 7'd64);
    repeat (30) send_item(random_item());
  endtask

  initial begin
    win_min_line = 16'd0;
    win_max_line = 16'd65535;
    win_upper_on = 1'b0;
    rank_descending = 1'b0;
    tracked_values = 7'd64;
    foreach (hist_counts[s, v]) hist_counts[s][v] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_window();
    test_random();
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("tb_top failed");
    $finish;
  end
endmodule
